FILE: rtl/lwt_pkg.sv
// Shared types, control codes and constants of the LQR wheel torque controller.
package lwt_pkg;

   localparam int DATA_W    = 32;
   localparam int PROD_W    = 64;
   localparam int ACC_W     = 48;
   localparam int ACC_SHIFT = 16;
   localparam int NUM_GAINS = 6;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 4;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // 0.002 in Q0.32
   localparam fix_type  OFFSET_STEP  = 32'sd8589935;
   localparam prod_type OFFSET_ROUND = 64'sd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POSITION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VELOCITY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PITCH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PITCH_RATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_YAW        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_YAW_RATE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_ENABLE    = 3'd6;

   localparam int GAIN_RESET [NUM_GAINS] = '{
      -488469, -385149, -1248874, -224783, 110317, 24917
   };

   localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;

   typedef struct packed {
      fix_type position;
      fix_type velocity;
      fix_type pitch;
      fix_type pitch_rate;
      fix_type yaw_delta;
      fix_type yaw_delta_rate;
      fix_type target_position;
      fix_type target_velocity;
      fix_type target_yaw_delta;
   } req_data_type;

   typedef struct packed {
      fix_type left_torque;
      fix_type right_torque;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ERR_HOLD,
      ERR_SPEED,
      ERR_POS,
      ERR_VEL,
      ERR_PITCH,
      ERR_PITCH_RATE,
      ERR_YAW,
      ERR_YAW_RATE
   } err_op_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_STEP,
      MUL_GAIN_POS,
      MUL_GAIN_VEL,
      MUL_GAIN_PITCH,
      MUL_GAIN_PITCH_RATE,
      MUL_GAIN_YAW,
      MUL_GAIN_YAW_RATE
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_OFFSET,
      ACC_LOAD,
      ACC_ADD,
      ACC_NEG
   } acc_op_type;

   typedef enum logic [1:0] {
      FIN_HOLD,
      FIN_SAVE_BAL,
      FIN_MIX,
      FIN_LEFT
   } fin_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_PUBLISH
   } seq_op_type;

   typedef struct packed {
      err_op_type      err;
      mul_op_type      mul;
      acc_op_type      acc;
      fin_op_type      fin;
      seq_op_type      seq;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic       capture;
      logic       publish;
      err_op_type err;
      mul_op_type mul;
      acc_op_type acc;
      fin_op_type fin;
   } ctl_type;

endpackage

FILE: rtl/lqr_wheel_torque_controller.sv
// Top level of the LQR wheel torque controller for a two-wheel balancing robot.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (state and targets)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (left/right torque)
//   csr      in         csr_write            csr_index, csr_data
//
// An item is accepted at the idle step and then runs 15 control store steps that share
// the single 32x32 multiplier forming the offset step and all six gain products.
// The result sits in an output register; the next item is taken while it waits.
// A stalled result holds the program at its publish step until the beat completes.
// Reset restores the default gains, clears drive_enable and the position offset.
module lqr_wheel_torque_controller
   import lwt_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int GAIN_WIDTH = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAIN_WIDTH-1:0] csr_data
);

   ctl_type ctl;

   lwt_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   lwt_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .GAIN_WIDTH (GAIN_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .ctl       (ctl),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/lwt_sequencer.sv
// Microcode sequencer: step counter, control store and handshake control.
module lwt_sequencer
   import lwt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output ctl_type ctl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   uword_type       word;
   logic            slot_free;

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{err: ERR_HOLD, mul: MUL_HOLD, acc: ACC_HOLD, fin: FIN_HOLD,
            seq: SEQ_NEXT, target: STEP_IDLE};
      unique case (pc)
         4'd0: begin
            w.seq = SEQ_WAIT_REQ;
         end
         4'd1: begin
            w.err = ERR_SPEED;
         end
         4'd2: begin
            w.mul = MUL_STEP;
         end
         4'd3: begin
            w.acc = ACC_OFFSET;
         end
         4'd4: begin
            w.err = ERR_POS;
         end
         4'd5: begin
            w.mul = MUL_GAIN_POS;
            w.err = ERR_VEL;
         end
         4'd6: begin
            w.acc = ACC_LOAD;
            w.mul = MUL_GAIN_VEL;
            w.err = ERR_PITCH;
         end
         4'd7: begin
            w.acc = ACC_ADD;
            w.mul = MUL_GAIN_PITCH;
            w.err = ERR_PITCH_RATE;
         end
         4'd8: begin
            w.acc = ACC_ADD;
            w.mul = MUL_GAIN_PITCH_RATE;
            w.err = ERR_YAW;
         end
         4'd9: begin
            w.acc = ACC_ADD;
            w.mul = MUL_GAIN_YAW;
            w.err = ERR_YAW_RATE;
         end
         4'd10: begin
            w.fin = FIN_SAVE_BAL;
            w.acc = ACC_LOAD;
            w.mul = MUL_GAIN_YAW_RATE;
         end
         4'd11: begin
            w.acc = ACC_ADD;
         end
         4'd12: begin
            w.fin = FIN_MIX;
            w.acc = ACC_NEG;
         end
         4'd13: begin
            w.fin = FIN_MIX;
         end
         4'd14: begin
            w.fin = FIN_LEFT;
         end
         4'd15: begin
            w.seq    = SEQ_PUBLISH;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      word         = ucode(pc_ff);
      req_stall    = reset || (pc_ff != STEP_IDLE);
      slot_free    = !rsp_valid_ff || !rsp_stall;
      pc_in        = pc_ff + 1'b1;
      ctl.capture  = 1'b0;
      ctl.publish  = 1'b0;
      ctl.err      = word.err;
      ctl.mul      = word.mul;
      ctl.acc      = word.acc;
      ctl.fin      = word.fin;
      unique case (word.seq)
         SEQ_NEXT: begin
         end
         SEQ_WAIT_REQ: begin
            ctl.capture = req_valid && !req_stall;
            if (!ctl.capture) begin
               pc_in = pc_ff;
            end
         end
         SEQ_PUBLISH: begin
            if (slot_free) begin
               ctl.publish = 1'b1;
               pc_in       = word.target;
            end else begin
               pc_in = pc_ff;
            end
         end
         default: begin
            pc_in = STEP_IDLE;
         end
      endcase
      if (ctl.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/lwt_datapath.sv
// Datapath: gain registers, error unit, shared multiplier, saturating accumulators.
module lwt_datapath
   import lwt_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int GAIN_WIDTH = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAIN_WIDTH-1:0] csr_data,
   input  req_data_type          req_data,
   input  ctl_type               ctl,
   output rsp_data_type          rsp_data
);

   localparam int       DIFF_W     = DATA_W + 2;
   localparam int       ONE_F      = 1 << FRAC_BITS;
   localparam fix_type  CAP_HI     = DATA_W'(10 * ONE_F);
   localparam fix_type  FRIC_TH    = DATA_W'((2 * ONE_F + 5) / 10);
   localparam fix_type  FRIC_TH_N  = -FRIC_TH;
   localparam fix_type  FRIC_POS   = DATA_W'((11 * ONE_F + 50) / 100);
   localparam fix_type  FRIC_NEG   = DATA_W'((ONE_F + 5) / 10);
   localparam fix_type  FIX_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam fix_type  FIX_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
   localparam prod_type PROD_MAX   = {1'b0, {(PROD_W-1){1'b1}}};
   localparam prod_type PROD_MIN   = {1'b1, {(PROD_W-1){1'b0}}};
   localparam prod_type ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam acc_type  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic prod_type sat_add(input prod_type a, input prod_type b);
      logic signed [PROD_W:0] s;
      s = (PROD_W+1)'(a) + (PROD_W+1)'(b);
      if (s[PROD_W] != s[PROD_W-1]) begin
         return s[PROD_W] ? PROD_MIN : PROD_MAX;
      end
      return s[PROD_W-1:0];
   endfunction

   function automatic prod_type sat_neg(input prod_type v);
      return (v == PROD_MIN) ? PROD_MAX : -v;
   endfunction

   logic signed [GAIN_WIDTH-1:0] gain_ff [NUM_GAINS];
   logic signed [GAIN_WIDTH-1:0] gain_in [NUM_GAINS];
   logic                         enable_ff, enable_in;
   acc_type                      offset_acc_ff, offset_acc_in;
   req_data_type                 item_ff, item_in;
   fix_type                      err_ff, err_in;
   prod_type                     prod_ff, prod_in;
   prod_type                     sum_ff, sum_in;
   prod_type                     nbal_ff, nbal_in;
   prod_type                     mix_ff, mix_in;
   fix_type                      tq_ff, tq_in;
   fix_type                      left_ff, left_in;
   rsp_data_type                 rsp_ff, rsp_in;

   fix_type                      offset;
   fix_type                      op_a, op_b, op_c;
   logic signed [DIFF_W-1:0]     diff;
   fix_type                      err_sat;
   fix_type                      mul_b;
   prod_type                     mul_p;
   prod_type                     inc_full;
   logic signed [ACC_W:0]        acc_sum;
   prod_type                     tq_round;
   prod_type                     tq_shift;

   always_comb begin
      gain_in   = gain_ff;
      enable_in = enable_ff;
      if (csr_write) begin
         if (csr_index == CSR_DRIVE_ENABLE) begin
            enable_in = csr_data[0];
         end else if (csr_index < CSR_DRIVE_ENABLE) begin
            gain_in[csr_index] = csr_data;
         end
      end
   end

   // error unit
   always_comb begin
      offset = DATA_W'(offset_acc_ff >>> ACC_SHIFT);
      op_a   = '0;
      op_b   = '0;
      op_c   = '0;
      unique case (ctl.err)
         ERR_HOLD: begin
         end
         ERR_SPEED: begin
            op_a = item_ff.target_velocity;
         end
         ERR_POS: begin
            op_a = item_ff.position;
            op_b = item_ff.target_position;
            op_c = offset;
         end
         ERR_VEL: begin
            op_a = item_ff.velocity;
            op_b = item_ff.target_velocity;
         end
         ERR_PITCH: begin
            op_a = item_ff.pitch;
         end
         ERR_PITCH_RATE: begin
            op_a = item_ff.pitch_rate;
         end
         ERR_YAW: begin
            op_a = item_ff.yaw_delta;
            op_b = item_ff.target_yaw_delta;
         end
         ERR_YAW_RATE: begin
            op_a = item_ff.yaw_delta_rate;
         end
      endcase
      diff = DIFF_W'(op_a) - DIFF_W'(op_b) - DIFF_W'(op_c);
      priority if (diff > DIFF_W'(FIX_MAX)) begin
         err_sat = FIX_MAX;
      end else if (diff < DIFF_W'(FIX_MIN)) begin
         err_sat = FIX_MIN;
      end else begin
         err_sat = diff[DATA_W-1:0];
      end
      err_in = (ctl.err == ERR_HOLD) ? err_ff : err_sat;
   end

   // shared multiplier
   always_comb begin
      unique case (ctl.mul)
         MUL_HOLD:            mul_b = '0;
         MUL_STEP:            mul_b = OFFSET_STEP;
         MUL_GAIN_POS:        mul_b = DATA_W'(gain_ff[CSR_GAIN_POSITION]);
         MUL_GAIN_VEL:        mul_b = DATA_W'(gain_ff[CSR_GAIN_VELOCITY]);
         MUL_GAIN_PITCH:      mul_b = DATA_W'(gain_ff[CSR_GAIN_PITCH]);
         MUL_GAIN_PITCH_RATE: mul_b = DATA_W'(gain_ff[CSR_GAIN_PITCH_RATE]);
         MUL_GAIN_YAW:        mul_b = DATA_W'(gain_ff[CSR_GAIN_YAW]);
         MUL_GAIN_YAW_RATE:   mul_b = DATA_W'(gain_ff[CSR_GAIN_YAW_RATE]);
      endcase
      mul_p   = err_ff * mul_b;
      prod_in = (ctl.mul == MUL_HOLD) ? prod_ff : mul_p;
   end

   // accumulators
   always_comb begin
      inc_full      = (prod_ff + OFFSET_ROUND) >>> ACC_SHIFT;
      acc_sum       = (ACC_W+1)'(offset_acc_ff) + (ACC_W+1)'(inc_full);
      offset_acc_in = offset_acc_ff;
      sum_in        = sum_ff;
      unique case (ctl.acc)
         ACC_HOLD: begin
         end
         ACC_OFFSET: begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               offset_acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               offset_acc_in = acc_sum[ACC_W-1:0];
            end
         end
         ACC_LOAD: begin
            sum_in = prod_ff;
         end
         ACC_ADD: begin
            sum_in = sat_add(sum_ff, prod_ff);
         end
         ACC_NEG: begin
            sum_in = sat_neg(sum_ff);
         end
         default: begin
         end
      endcase
   end

   // torque shaping
   always_comb begin
      tq_round = sat_add(mix_ff, ROUND_HALF);
      tq_shift = tq_round >>> FRAC_BITS;
      priority if (tq_shift > PROD_W'(CAP_HI)) begin
         tq_in = CAP_HI;
      end else if (tq_shift < PROD_W'(FIX_MIN)) begin
         tq_in = FIX_MIN;
      end else begin
         tq_in = tq_shift[DATA_W-1:0];
      end
      nbal_in = nbal_ff;
      mix_in  = mix_ff;
      left_in = left_ff;
      unique case (ctl.fin)
         FIN_HOLD: begin
         end
         FIN_SAVE_BAL: begin
            nbal_in = sat_neg(sum_ff);
         end
         FIN_MIX: begin
            mix_in = sat_add(nbal_ff, sum_ff);
         end
         FIN_LEFT: begin
            priority if (tq_ff > FRIC_TH) begin
               left_in = tq_ff - FRIC_POS;
            end else if (tq_ff < FRIC_TH_N) begin
               left_in = tq_ff + FRIC_NEG;
            end else begin
               left_in = tq_ff;
            end
         end
      endcase
      item_in = ctl.capture ? req_data : item_ff;
      rsp_in  = rsp_ff;
      if (ctl.publish) begin
         if (enable_ff) begin
            rsp_in = '{left_torque: left_ff, right_torque: tq_ff};
         end else begin
            rsp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GAINS; i++) begin
            gain_ff[i] <= GAIN_WIDTH'(GAIN_RESET[i]);
         end
         enable_ff     <= 1'b0;
         offset_acc_ff <= '0;
      end else begin
         gain_ff       <= gain_in;
         enable_ff     <= enable_in;
         offset_acc_ff <= offset_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      err_ff  <= err_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      nbal_ff <= nbal_in;
      mix_ff  <= mix_in;
      tq_ff   <= tq_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/lwt_checker.sv
// Port checker for the LQR wheel torque controller and its bind to the top level.
module lwt_checker
   import lwt_pkg::*;
#(
   parameter int FRAC_BITS  = 16
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_data_type          rsp_data
);

   localparam fix_type CAP_HI = DATA_W'(10 * (1 << FRAC_BITS));

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall ##14 req_stall)
      else $error("input taken again before the program finished");

   a_torque_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.left_torque <= CAP_HI) && (rsp_data.right_torque <= CAP_HI))
      else $error("torque above upper cap");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a program in flight");

endmodule

bind lqr_wheel_torque_controller lwt_checker #(
   .FRAC_BITS  (FRAC_BITS)
) u_lwt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: bench/lqr_wheel_torque_controller_test.sv
// Self-checking bench for the LQR wheel torque controller: directed table, random phases.
`timescale 1ns / 100ps

module lqr_wheel_torque_controller_test;
   import lwt_pkg::*;

   localparam int FRAC          = 16;
   localparam int GAIN_W        = 24;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 40;
   localparam int NUM_PHASES    = 8;

   typedef logic signed [GAIN_W-1:0] gain_type;

   typedef enum logic [2:0] {
      SET_RESET,
      SET_DEFAULT_ON,
      SET_UNIT_PITCH,
      SET_MAX,
      SET_MIN
   } setting_type;

   typedef enum logic [1:0] {
      DRIFT_NONE,
      DRIFT_UP,
      DRIFT_DOWN
   } drift_type;

   typedef struct packed {
      setting_type  setting;
      req_data_type beat;
      logic         given;
      rsp_data_type result;
   } directed_row_type;

   localparam fix_type  HI      = 32'sh7fff_ffff;
   localparam fix_type  LO      = 32'sh8000_0000;
   localparam gain_type GAIN_HI = 24'sh7f_ffff;
   localparam gain_type GAIN_LO = 24'sh80_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] GAIN_CSR [NUM_GAINS] = '{
      CSR_GAIN_POSITION, CSR_GAIN_VELOCITY, CSR_GAIN_PITCH,
      CSR_GAIN_PITCH_RATE, CSR_GAIN_YAW, CSR_GAIN_YAW_RATE
   };

   localparam longint LONG_MAX      = 64'sh7fff_ffff_ffff_ffff;
   localparam longint LONG_MIN      = 64'sh8000_0000_0000_0000;
   localparam longint ACC_TOP       = 64'sh0000_7fff_ffff_ffff;
   localparam longint ACC_BOTTOM    = -ACC_TOP - 64'sd1;
   localparam longint HALF_LSB      = 64'sd1 <<< (FRAC - 1);
   localparam longint TORQUE_CAP    = 64'sd655360;
   localparam longint FRICTION_BAND = 64'sd13107;
   localparam longint FRICTION_DROP = 64'sd7209;
   localparam longint FRICTION_LIFT = 64'sd6554;

   localparam int        PHASE_ITEMS [NUM_PHASES] = '{50, 50, 540, 50, 100, 50, 40, 40};
   localparam drift_type PHASE_DRIFT [NUM_PHASES] = '{
      DRIFT_NONE, DRIFT_NONE, DRIFT_DOWN, DRIFT_NONE,
      DRIFT_UP, DRIFT_NONE, DRIFT_NONE, DRIFT_NONE
   };

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_data_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_data_type         rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAIN_POSITION;
   logic [GAIN_W-1:0]    csr_data  = '0;

   gain_type     gain_model [NUM_GAINS];
   gain_type     staged_gain [NUM_GAINS];
   logic         enable_model;
   longint       offset_acc;
   rsp_data_type expected_torques [$];
   int           fail_count;
   int           send_idle_weight;
   int           stall_weight;
   int           stall_left;

   directed_row_type directed_rows [26] = '{
      '{SET_RESET, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0}},
      '{SET_RESET, '{HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b1, '{0, 0}},
      '{SET_RESET, '{LO, LO, LO, LO, LO, LO, LO, LO, LO}, 1'b1, '{0, 0}},
      '{SET_RESET, '{0, 0, 0, 0, 0, 0, 0, HI, 0}, 1'b1, '{0, 0}},
      '{SET_DEFAULT_ON, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{0, 0, 6554, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{HI, 0, 0, 0, 0, 0, LO, 0, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{LO, 0, 0, 0, 0, 0, HI, 0, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{0, HI, 0, 0, 0, 0, 0, LO, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{0, LO, 0, 0, 0, 0, 0, HI, 0}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{0, 0, 0, 0, HI, 0, 0, 0, LO}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{0, 0, 0, 0, LO, 0, 0, 0, HI}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{LO, LO, LO, LO, LO, LO, LO, LO, LO}, 1'b0, '0},
      '{SET_DEFAULT_ON, '{1, -1, -6554, 13107, 65536, -65536, 0, 32768, -1}, 1'b0, '0},
      '{SET_UNIT_PITCH, '{0, 0, 13107, 0, 0, 0, 0, 0, 0}, 1'b1, '{13107, 13107}},
      '{SET_UNIT_PITCH, '{0, 0, 13108, 0, 0, 0, 0, 0, 0}, 1'b1, '{5899, 13108}},
      '{SET_UNIT_PITCH, '{0, 0, -13107, 0, 0, 0, 0, 0, 0}, 1'b1, '{-13107, -13107}},
      '{SET_UNIT_PITCH, '{0, 0, -13108, 0, 0, 0, 0, 0, 0}, 1'b1, '{-6554, -13108}},
      '{SET_UNIT_PITCH, '{0, 0, 655361, 0, 0, 0, 0, 0, 0}, 1'b1, '{648151, 655360}},
      '{SET_UNIT_PITCH, '{0, 0, HI, 0, 0, 0, 0, 0, 0}, 1'b1, '{648151, 655360}},
      '{SET_UNIT_PITCH, '{0, 0, LO, 0, 0, 0, 0, 0, 0}, 1'b1, '{-2147477094, LO}},
      '{SET_MAX, '{HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b0, '0},
      '{SET_MAX, '{HI, LO, HI, LO, HI, LO, LO, HI, LO}, 1'b0, '0},
      '{SET_MIN, '{HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b0, '0},
      '{SET_MIN, '{LO, LO, LO, LO, LO, LO, LO, LO, LO}, 1'b0, '0}
   };

   lqr_wheel_torque_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint sat64(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? LONG_MIN : LONG_MAX;
      end
      return s;
   endfunction

   function automatic longint neg64(longint v);
      return (v == LONG_MIN) ? LONG_MAX : -v;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sh7fff_ffff) begin
         return 64'sh7fff_ffff;
      end
      if (v < -64'sh8000_0000) begin
         return -64'sh8000_0000;
      end
      return v;
   endfunction

   function automatic longint to_torque(longint sum);
      longint t;
      t = clamp32(sat64(sum, HALF_LSB) >>> FRAC);
      return (t > TORQUE_CAP) ? TORQUE_CAP : t;
   endfunction

   function automatic rsp_data_type predict_torques(req_data_type beat);
      longint x, dx, th, dth, yw, dyw, tx, ts, tyw;
      longint offset_step, offset, bal, yaw, left, right;
      rsp_data_type result;
      x   = longint'($signed(beat.position));
      dx  = longint'($signed(beat.velocity));
      th  = longint'($signed(beat.pitch));
      dth = longint'($signed(beat.pitch_rate));
      yw  = longint'($signed(beat.yaw_delta));
      dyw = longint'($signed(beat.yaw_delta_rate));
      tx  = longint'($signed(beat.target_position));
      ts  = longint'($signed(beat.target_velocity));
      tyw = longint'($signed(beat.target_yaw_delta));

      offset_step = (ts * longint'(OFFSET_STEP) + longint'(OFFSET_ROUND)) >>> ACC_SHIFT;
      offset_acc = offset_acc + offset_step;
      if (offset_acc > ACC_TOP) begin
         offset_acc = ACC_TOP;
      end else if (offset_acc < ACC_BOTTOM) begin
         offset_acc = ACC_BOTTOM;
      end
      offset = offset_acc >>> ACC_SHIFT;

      bal = clamp32(x - tx - offset) * longint'(gain_model[CSR_GAIN_POSITION]);
      bal = sat64(bal, clamp32(dx - ts) * longint'(gain_model[CSR_GAIN_VELOCITY]));
      bal = sat64(bal, th * longint'(gain_model[CSR_GAIN_PITCH]));
      bal = sat64(bal, dth * longint'(gain_model[CSR_GAIN_PITCH_RATE]));
      yaw = clamp32(yw - tyw) * longint'(gain_model[CSR_GAIN_YAW]);
      yaw = sat64(yaw, dyw * longint'(gain_model[CSR_GAIN_YAW_RATE]));

      left  = to_torque(sat64(neg64(bal), yaw));
      right = to_torque(sat64(neg64(bal), neg64(yaw)));
      if (left > FRICTION_BAND) begin
         left = left - FRICTION_DROP;
      end else if (left < -FRICTION_BAND) begin
         left = left + FRICTION_LIFT;
      end
      if (!enable_model) begin
         left  = 0;
         right = 0;
      end
      result.left_torque  = left[31:0];
      result.right_torque = right[31:0];
      return result;
   endfunction

   function automatic fix_type random_fix();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom;
         3, 4:    return int'($urandom_range(0, 393216)) - 196608;
         5:       return int'($urandom_range(0, 32768)) - 16384;
         6: begin
            case ($urandom_range(0, 4))
               0:       return HI;
               1:       return LO;
               2:       return 0;
               3:       return 1;
               default: return -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               return HI - fix_type'($urandom_range(0, 255));
            end
            return LO + fix_type'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic gain_type random_gain(int i, int mode);
      case (mode)
         0:       return gain_type'(GAIN_RESET[i] + int'($urandom_range(0, 131072)) - 65536);
         1:       return gain_type'($urandom);
         2:       return gain_type'(int'($urandom_range(0, 8192)) - 4096);
         default: begin
            case ($urandom_range(0, 4))
               0:       return GAIN_HI;
               1:       return GAIN_LO;
               2:       return '0;
               3:       return -24'sd65536;
               default: return gain_type'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic req_data_type random_beat(drift_type drift);
      req_data_type beat;
      beat = {random_fix(), random_fix(), random_fix(), random_fix(), random_fix(),
              random_fix(), random_fix(), random_fix(), random_fix()};
      case (drift)
         DRIFT_UP:   beat.target_velocity = HI - fix_type'($urandom_range(0, 1 << 20));
         DRIFT_DOWN: beat.target_velocity = LO + fix_type'($urandom_range(0, 1 << 20));
         default:    ;
      endcase
      return beat;
   endfunction

   task automatic send_item(input req_data_type beat, input logic given,
                            input rsp_data_type typed_result);
      rsp_data_type predicted;
      while (send_idle_weight != 0 && $urandom_range(0, 9) < send_idle_weight) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = predict_torques(beat);
      expected_torques.push_back(given ? typed_result : predicted);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_torques.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int sender, input int receiver);
      @(posedge clock);
      send_idle_weight = sender;
      stall_weight     = receiver;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic en);
      foreach (GAIN_CSR[i]) begin
         csr_write <= 1'b1;
         csr_index <= GAIN_CSR[i];
         csr_data  <= staged_gain[i];
         gain_model[GAIN_CSR[i]] = staged_gain[i];
         @(negedge clock);
      end
      if ($urandom_range(0, 2) == 0) begin
         csr_index <= CSR_UNUSED;
         csr_data  <= GAIN_W'($urandom);
         @(negedge clock);
      end
      csr_index <= CSR_DRIVE_ENABLE;
      csr_data  <= {23'($urandom), en};
      enable_model = en;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_setting(input setting_type setting);
      foreach (staged_gain[i]) begin
         staged_gain[i] = '0;
      end
      case (setting)
         SET_DEFAULT_ON: begin
            foreach (staged_gain[i]) begin
               staged_gain[i] = gain_type'(GAIN_RESET[i]);
            end
         end
         SET_UNIT_PITCH: staged_gain[CSR_GAIN_PITCH] = -24'sd65536;
         SET_MAX: begin
            foreach (staged_gain[i]) begin
               staged_gain[i] = GAIN_HI;
            end
         end
         SET_MIN: begin
            foreach (staged_gain[i]) begin
               staged_gain[i] = GAIN_LO;
            end
         end
         default: ;
      endcase
      program_registers(1'b1);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < stall_weight) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_torques.size() == 0) begin
            $error("unexpected result beat: left %0d right %0d",
                   rsp_data.left_torque, rsp_data.right_torque);
            fail_count++;
         end else begin
            want = expected_torques.pop_front();
            if (rsp_data.left_torque !== want.left_torque) begin
               $error("left_torque expected %0d got %0d",
                      want.left_torque, rsp_data.left_torque);
               fail_count++;
            end
            if (rsp_data.right_torque !== want.right_torque) begin
               $error("right_torque expected %0d got %0d",
                      want.right_torque, rsp_data.right_torque);
               fail_count++;
            end
         end
      end
   end

   initial begin
      setting_type current;
      int mode;
      foreach (gain_model[i]) begin
         gain_model[i] = gain_type'(GAIN_RESET[i]);
      end
      enable_model     = 1'b0;
      offset_acc       = 0;
      fail_count       = 0;
      send_idle_weight = 0;
      stall_weight     = 0;
      stall_left       = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(3, 3);

      current = SET_RESET;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != current) begin
            drain_and_settle();
            apply_setting(directed_rows[i].setting);
            current = directed_rows[i].setting;
         end
         send_item(directed_rows[i].beat, directed_rows[i].given, directed_rows[i].result);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_and_settle();
         if (p == NUM_PHASES - 1) begin
            set_idling(0, 0);
         end else begin
            set_idling($urandom_range(0, 8), $urandom_range(0, 8));
         end
         mode = $urandom_range(0, 3);
         foreach (staged_gain[i]) begin
            staged_gain[i] = random_gain(i, mode);
         end
         program_registers($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS[p]) begin
            send_item(random_beat(PHASE_DRIFT[p]), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_torques.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lwt_pkg.sv
rtl/lwt_sequencer.sv
rtl/lwt_datapath.sv
rtl/lqr_wheel_torque_controller.sv
rtl/lwt_checker.sv
bench/lqr_wheel_torque_controller_test.sv
